>>> rtl/dldw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal LCD digit writer package
// Widths, segment patterns and the microcode program of the digit writer.
// ----------------------------------------------------------------------------
package dldw_pkg;

	localparam int NUMBER_W        = 31;
	localparam int BIT_CNT_W       = $clog2(NUMBER_W + 1);
	localparam int BCD_DIGITS      = 10;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int ROWS            = 4;
	localparam int DIGIT_COUNT_DEF = 6;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SHIFT,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_NO_INPUT,
		COND_MORE_BITS,
		COND_NOT_DONE
	} cond_t;

	typedef logic [1:0] pc_t;

	localparam pc_t PC_LOAD  = 2'd0;
	localparam pc_t PC_SHIFT = 2'd1;
	localparam pc_t PC_EMIT  = 2'd2;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   jump;
		pc_t   fall;
	} cw_t;

	typedef struct packed {
		logic in_valid;
		logic more_bits;
		logic emit_fire;
		logic emit_last;
	} status_t;

	typedef struct packed {
		op_t op;
	} ctrl_t;

	function automatic cw_t microcode(input pc_t pc);
		cw_t cw;
		case (pc)
			PC_LOAD:  cw = '{op: OP_LOAD,  cond: COND_NO_INPUT,  jump: PC_LOAD,  fall: PC_SHIFT};
			PC_SHIFT: cw = '{op: OP_SHIFT, cond: COND_MORE_BITS, jump: PC_SHIFT, fall: PC_EMIT};
			PC_EMIT:  cw = '{op: OP_EMIT,  cond: COND_NOT_DONE,  jump: PC_EMIT,  fall: PC_LOAD};
			default:  cw = '{op: OP_LOAD,  cond: COND_NO_INPUT,  jump: PC_LOAD,  fall: PC_LOAD};
		endcase
		return cw;
	endfunction

	function automatic logic [15:0] digit_pattern(input logic [3:0] digit);
		logic [15:0] pat;
		case (digit)
			4'd0:    pat = 16'h1551;
			4'd1:    pat = 16'h8110;
			4'd2:    pat = 16'h11e1;
			4'd3:    pat = 16'h11b1;
			4'd4:    pat = 16'h05b0;
			4'd5:    pat = 16'h14b1;
			4'd6:    pat = 16'h14f1;
			4'd7:    pat = 16'h1110;
			4'd8:    pat = 16'h15f1;
			4'd9:    pat = 16'h15b1;
			default: pat = 16'h0000;
		endcase
		return pat;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dldw_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Digit writer sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module dldw_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  dldw_pkg::status_t status,
	output dldw_pkg::ctrl_t   ctrl
);
	import dldw_pkg::*;

	pc_t  pc_q;
	pc_t  pc_next;
	cw_t  cw;
	logic taken;

	always_comb begin
		cw = microcode(pc_q);
	end

	always_comb begin
		case (cw.cond)
			COND_NO_INPUT:  taken = !status.in_valid;
			COND_MORE_BITS: taken = status.more_bits;
			COND_NOT_DONE:  taken = !(status.emit_fire && status.emit_last);
			default:        taken = 1'b0;
		endcase
		pc_next = taken ? cw.jump : cw.fall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_comb begin
		ctrl.op = cw.op;
	end

endmodule
`default_nettype wire

>>> rtl/decimal_lcd_digit_writer.sv
// After a number is accepted, the binary to decimal conversion runs its
// 31 shift-and-adjust steps before the first digit word appears.
// Then one digit word per cycle follows while the receiver does not stall;
// no new number is accepted until the last digit word of the previous one.
// Reset clears the sequencer, the output valid and the whole LCD image.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal LCD digit writer
// Converts a number to decimal and merges its digit segments into the LCD image.
// ----------------------------------------------------------------------------
module decimal_lcd_digit_writer #(
	parameter int DIGIT_COUNT = dldw_pkg::DIGIT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dldw_pkg::NUMBER_W-1:0] number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    digit_position,
	output logic [3:0]                    digit_value,
	output logic [1:0]                    byte_column,
	output logic [7:0]                    row_byte_0,
	output logic [7:0]                    row_byte_1,
	output logic [7:0]                    row_byte_2,
	output logic [7:0]                    row_byte_3,
	output logic                          last_digit
);
	import dldw_pkg::*;

	localparam int COLUMNS = (DIGIT_COUNT + 1) / 2;
	localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	ctrl_t   ctrl;
	status_t status;

	logic [NUMBER_W-1:0]  shreg_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BIT_CNT_W-1:0] bits_q;
	logic [2:0]           pos_q;
	logic [7:0]           image_q [ROWS][COLUMNS];
	logic [7:0]           merged [ROWS];
	logic [15:0]          pat;
	logic [1:0]           col;
	logic [COL_W-1:0]     col_idx;
	logic                 accept;
	logic                 emit_fire;
	logic                 emit_last;
	logic                 out_valid_q;

	dldw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_stall  = (ctrl.op != OP_LOAD);
	assign accept    = in_valid && !in_stall;
	assign emit_fire = (ctrl.op == OP_EMIT) && (!out_valid_q || !out_stall);
	assign emit_last = (bcd_q[BCD_W-1:4] == '0) || (pos_q == 3'd0);

	always_comb begin
		status.in_valid  = in_valid;
		status.more_bits = (bits_q != BIT_CNT_W'(1));
		status.emit_fire = emit_fire;
		status.emit_last = emit_last;
	end

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign pat     = digit_pattern(bcd_q[3:0]);
	assign col     = pos_q[2:1];
	assign col_idx = col[COL_W-1:0];

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			if (pos_q[0]) begin
				merged[r] = {pat[15-4*r -: 4], image_q[r][col_idx][3:0]};
			end else begin
				merged[r] = {image_q[r][col_idx][7:4], pat[15-4*r -: 4]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shreg_q <= number;
			bcd_q   <= '0;
			bits_q  <= BIT_CNT_W'(NUMBER_W);
			pos_q   <= 3'(DIGIT_COUNT - 1);
		end else if (ctrl.op == OP_SHIFT) begin
			shreg_q <= {shreg_q[NUMBER_W-2:0], 1'b0};
			bcd_q   <= {bcd_adj[BCD_W-2:0], shreg_q[NUMBER_W-1]};
			bits_q  <= bits_q - BIT_CNT_W'(1);
		end else if (emit_fire) begin
			bcd_q <= {4'd0, bcd_q[BCD_W-1:4]};
			pos_q <= pos_q - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLUMNS; c++) begin
					image_q[r][c] <= 8'h00;
				end
			end
		end else if (emit_fire) begin
			for (int r = 0; r < ROWS; r++) begin
				image_q[r][col_idx] <= merged[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			digit_position <= pos_q;
			digit_value    <= bcd_q[3:0];
			byte_column    <= col;
			row_byte_0     <= merged[0];
			row_byte_1     <= merged[1];
			row_byte_2     <= merged[2];
			row_byte_3     <= merged[3];
			last_digit     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_starts_shift: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (ctrl.op == OP_SHIFT))
		else $error("An accepted number did not start the conversion.");

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> (bcd_q[3:0] <= 4'd9))
		else $error("A digit outside zero to nine was written.");

	a_word_only_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op != OP_EMIT) |=> !$rose(out_valid))
		else $error("A digit word appeared outside the emit step.");

	a_last_returns_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && emit_last) |=> (ctrl.op == OP_LOAD))
		else $error("The sequencer did not return to load after the last digit.");

endmodule
`default_nettype wire

>>> tb/sv/decimal_lcd_digit_writer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal LCD digit writer checker
// Watches both channels of the digit writer and keeps its own copy of the LCD
// image. Each accepted number is turned into the digit words that it should
// produce, and each accepted digit word is compared field by field with the
// oldest of them.
// ----------------------------------------------------------------------------
module decimal_lcd_digit_writer_checker #(
	parameter int DIGIT_COUNT = dldw_pkg::DIGIT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [dldw_pkg::NUMBER_W-1:0] number,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [2:0]                    digit_position,
	input  logic [3:0]                    digit_value,
	input  logic [1:0]                    byte_column,
	input  logic [7:0]                    row_byte_0,
	input  logic [7:0]                    row_byte_1,
	input  logic [7:0]                    row_byte_2,
	input  logic [7:0]                    row_byte_3,
	input  logic                          last_digit,
	output int unsigned                   words_pending,
	output int unsigned                   fail_count
);

	localparam int COLUMNS = (DIGIT_COUNT + 1) / 2;

	localparam logic [15:0] SEGMENT_PATTERN [0:9] = '{
		16'h1551, 16'h8110, 16'h11e1, 16'h11b1, 16'h05b0,
		16'h14b1, 16'h14f1, 16'h1110, 16'h15f1, 16'h15b1
	};

	typedef struct packed {
		logic [2:0]      position;
		logic [3:0]      digit;
		logic [1:0]      column;
		logic [3:0][7:0] rows;
		logic            last;
	} digit_word_t;

	logic [7:0]  lcd_image [dldw_pkg::ROWS][COLUMNS];
	digit_word_t expected_words [$];
	digit_word_t seen_word;
	digit_word_t oldest_word;

	initial begin
		words_pending = 0;
		fail_count = 0;
	end

	task automatic show_number(input logic [dldw_pkg::NUMBER_W-1:0] value);
		logic [31:0]  rest;
		logic [31:0]  scan;
		int unsigned  count;
		int unsigned  col;
		logic [2:0]   pos;
		logic [3:0]   digit;
		logic [15:0]  pat;
		logic [3:0]   nib;
		digit_word_t  word;
		rest = 32'(value);
		scan = 32'(value);
		count = 1;
		while (scan >= 10) begin
			scan = scan / 10;
			count++;
		end
		if (count > DIGIT_COUNT) begin
			count = DIGIT_COUNT;
		end
		for (int k = 0; k < count; k++) begin
			pos = 3'(DIGIT_COUNT - 1 - k);
			digit = 4'(rest % 10);
			rest = rest / 10;
			col = pos / 2;
			pat = SEGMENT_PATTERN[digit];
			for (int r = 0; r < dldw_pkg::ROWS; r++) begin
				nib = pat[15 - 4 * r -: 4];
				if (pos[0]) begin
					lcd_image[r][col][7:4] = nib;
				end else begin
					lcd_image[r][col][3:0] = nib;
				end
				word.rows[r] = lcd_image[r][col];
			end
			word.position = pos;
			word.digit = digit;
			word.column = 2'(col);
			word.last = (k + 1 == count);
			expected_words.push_back(word);
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	assign seen_word = '{
		position: digit_position,
		digit:    digit_value,
		column:   byte_column,
		rows:     {row_byte_3, row_byte_2, row_byte_1, row_byte_0},
		last:     last_digit
	};

	// Inputs change only at rising edges, so the values seen at the falling
	// edge are the ones the next rising edge will accept.
	always @(negedge clk) begin
		if (!arst_n) begin
			foreach (lcd_image[r, c]) begin
				lcd_image[r][c] = '0;
			end
			expected_words.delete();
		end else begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_words.size() == 0) begin
					$error("digit word at position %0d with no number pending", digit_position);
					fail_count++;
				end else begin
					oldest_word = expected_words.pop_front();
					compare_field("digit_position", 8'(oldest_word.position),
						8'(seen_word.position));
					compare_field("digit_value", 8'(oldest_word.digit), 8'(seen_word.digit));
					compare_field("byte_column", 8'(oldest_word.column), 8'(seen_word.column));
					for (int r = 0; r < dldw_pkg::ROWS; r++) begin
						compare_field($sformatf("row_byte_%0d", r), oldest_word.rows[r],
							seen_word.rows[r]);
					end
					compare_field("last_digit", 8'(oldest_word.last), 8'(seen_word.last));
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				show_number(number);
			end
		end
		words_pending = expected_words.size();
	end

endmodule

>>> tb/sv/decimal_lcd_digit_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal LCD digit writer testbench
// Feeds the digit writer a directed set of numbers, then random numbers of
// every length, under three mixes of sender gaps and receiver stalls. The
// checker beside the block predicts and compares every digit word.
// ----------------------------------------------------------------------------
module decimal_lcd_digit_writer_tb;

	localparam int DIGITS         = dldw_pkg::DIGIT_COUNT_DEF;
	localparam int NUMBER_W       = dldw_pkg::NUMBER_W;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int PHASE_ITEMS    = 43;
	localparam int DIRECTED_COUNT = 21;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [dldw_pkg::NUMBER_W-1:0] number;
	logic                          out_valid;
	logic                          out_stall;
	logic [2:0]                    digit_position;
	logic [3:0]                    digit_value;
	logic [1:0]                    byte_column;
	logic [7:0]                    row_byte_0;
	logic [7:0]                    row_byte_1;
	logic [7:0]                    row_byte_2;
	logic [7:0]                    row_byte_3;
	logic                          last_digit;
	int unsigned                   words_pending;
	int unsigned                   fail_count;
	int unsigned                   cycles = 0;
	int unsigned                   gap_pct = 0;
	int unsigned                   stall_pct = 0;
	int unsigned                   directed [DIRECTED_COUNT] = '{
		0, 1, 9, 10, 99, 100, 999999, 1000000,
		123456, 2147483647, 1073741824, 5, 654321, 86420, 13579,
		7, 42, 808080, 2222222, 31, 1234567890
	};

	decimal_lcd_digit_writer #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.number         (number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_position (digit_position),
		.digit_value    (digit_value),
		.byte_column    (byte_column),
		.row_byte_0     (row_byte_0),
		.row_byte_1     (row_byte_1),
		.row_byte_2     (row_byte_2),
		.row_byte_3     (row_byte_3),
		.last_digit     (last_digit)
	);

	decimal_lcd_digit_writer_checker #(
		.DIGIT_COUNT(DIGITS)
	) digit_word_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.number         (number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.digit_position (digit_position),
		.digit_value    (digit_value),
		.byte_column    (byte_column),
		.row_byte_0     (row_byte_0),
		.row_byte_1     (row_byte_1),
		.row_byte_2     (row_byte_2),
		.row_byte_3     (row_byte_3),
		.last_digit     (last_digit),
		.words_pending  (words_pending),
		.fail_count     (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("decimal_lcd_digit_writer test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_number(input logic [dldw_pkg::NUMBER_W-1:0] value);
		logic stalled;
		in_valid <= 1'b1;
		number <= value;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			number <= NUMBER_W'($urandom());
			repeat ($urandom_range(1, 45)) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (words_pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Most numbers are drawn with a uniformly chosen digit count so that short
	// and long numbers are equally common.
	function automatic logic [dldw_pkg::NUMBER_W-1:0] random_number();
		int unsigned     len;
		longint unsigned scale;
		longint unsigned lo;
		longint unsigned hi;
		if ($urandom_range(9) == 0) begin
			return NUMBER_W'($urandom());
		end
		len = $urandom_range(1, 10);
		scale = 1;
		repeat (len - 1) scale = scale * 10;
		lo = (len == 1) ? 0 : scale;
		hi = scale * 10 - 1;
		if (hi > 64'd2147483647) begin
			hi = 64'd2147483647;
		end
		return NUMBER_W'($urandom_range(32'(hi), 32'(lo)));
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		number = '0;
		out_stall = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 22;
		stall_pct = 82;
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			send_number(NUMBER_W'(directed[i]));
			if (i == 7) begin
				wait_for_drain();
			end
		end

		repeat (PHASE_ITEMS) send_number(random_number());
		gap_pct = 82;
		stall_pct = 22;
		repeat (PHASE_ITEMS) send_number(random_number());
		gap_pct = 0;
		stall_pct = 0;
		repeat (PHASE_ITEMS) send_number(random_number());

		wait_for_drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("decimal_lcd_digit_writer test passed");
		end else begin
			$display("decimal_lcd_digit_writer test failed");
		end
		$finish;
	end

endmodule
